### hw/rtl/dbsw_pkg.sv
// ============================================================================
// dbsw_pkg: shared types, constants and helpers for the stopwatch
// Widths, codes, register indexes and the mixed-radix digit arithmetic
// used to keep minutes, seconds and tenths without any division.
// ============================================================================
`default_nettype none

package dbsw_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int BUTTON_W     = 2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_TENTH    = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;
  localparam logic [1:0] REG_MODULUS  = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0]  DEBOUNCE_RESET = 8'd10;
  localparam logic [15:0] TENTH_RESET    = 16'd10;
  localparam logic [15:0] HOLD_RESET     = 16'd300;
  localparam logic [15:0] MODULUS_RESET  = 16'd36000;
  localparam logic [15:0] MODULUS_LIMIT  = 16'd36000;

  // item codes
  localparam logic            KIND_TICK   = 1'b0;
  localparam logic            LEVEL_PRESS = 1'b0;
  localparam logic [BUTTON_W-1:0] BTN_START  = 2'd0;
  localparam logic [BUTTON_W-1:0] BTN_PAUSE  = 2'd1;
  localparam logic [BUTTON_W-1:0] BTN_RESET  = 2'd2;
  localparam logic [BUTTON_W-1:0] BTN_FINISH = 2'd3;

  localparam logic [3:0] BLANK_SHAPE = 4'd10;

  localparam logic [3:0] RADIX_TEN = 4'd10;
  localparam logic [3:0] RADIX_SIX = 4'd6;

  // count reduction sequencer after a modulus change
  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_CONV
  } state_t;

  // count held as mixed-radix digits: mm:ss.t
  typedef struct packed {
    logic [3:0] min_ten;
    logic [3:0] min_one;
    logic [3:0] sec_ten;
    logic [3:0] sec_one;
    logic [3:0] tenth;
  } digits_t;

  // one digit position: optional doubling plus carry in, returns {carry, digit}
  function automatic logic [4:0] digit_step(input logic [3:0] d, input logic [3:0] radix,
                                            input logic dbl, input logic cin);
    logic [4:0] sum;
    logic [4:0] wrapped;
    sum     = (dbl ? {d, 1'b0} : {1'b0, d}) + {4'd0, cin};
    wrapped = sum - {1'b0, radix};
    if (sum >= {1'b0, radix}) begin
      digit_step = {1'b1, wrapped[3:0]};
    end else begin
      digit_step = {1'b0, sum[3:0]};
    end
  endfunction

  // whole count: d * (dbl ? 2 : 1) + cin, carried through all positions
  function automatic digits_t digits_step(input digits_t d, input logic dbl, input logic cin);
    logic [4:0] t;
    logic [4:0] so;
    logic [4:0] st;
    logic [4:0] mo;
    logic [4:0] mt;
    t  = digit_step(d.tenth,   RADIX_TEN, dbl, cin);
    so = digit_step(d.sec_one, RADIX_TEN, dbl, t[4]);
    st = digit_step(d.sec_ten, RADIX_SIX, dbl, so[4]);
    mo = digit_step(d.min_one, RADIX_TEN, dbl, st[4]);
    mt = digit_step(d.min_ten, RADIX_SIX, dbl, mo[4]);
    digits_step = '{min_ten: mt[3:0], min_one: mo[3:0], sec_ten: st[3:0],
                    sec_one: so[3:0], tenth: t[3:0]};
  endfunction

  function automatic logic [15:0] digits_bcd(input digits_t d);
    digits_bcd = {d.min_ten, d.min_one, d.sec_ten, d.sec_one};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dbsw_if.sv
// ============================================================================
// dbsw_if: valid/ready channels of the stopwatch
// One interface for input items (ticks and button edges), one for results.
// ============================================================================
`default_nettype none

interface dbsw_item_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [dbsw_pkg::BUTTON_W-1:0] button;
  logic                          level;

  modport source (output valid, output kind, output button, output level, input ready);
  modport sink   (input valid, input kind, input button, input level, output ready);
endinterface

interface dbsw_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  glyph;
  logic [15:0] display_bcd;
  logic        finished;

  modport source (output valid, output glyph, output display_bcd, output finished,
                  input ready);
  modport sink   (input valid, input glyph, input display_bcd, input finished,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/debounced_tenth_second_stopwatch.sv
// ============================================================================
// debounced_tenth_second_stopwatch: debounced four-button tenth-second stopwatch
// Ticks and button edges in, BCD mm:ss plus tenths digit out.
// ============================================================================
// Usage:
//   item   : valid/ready channel, one transaction per tick (kind 0) or button
//            edge (kind 1, button 0..3, level 0 press / 1 release).
//   result : valid/ready channel, at most one transaction per item: glyph,
//            display_bcd (mm:ss in BCD) and finished.
//   cfg_*  : write-only register port, cfg_index selects the register.
// Latency: a result shows up on result.valid in the cycle after its item is
//   taken. Throughput: one item per cycle while item.ready is high; each item is
//   handled in a single pass from the item handshake into the result register.
// Stall: the result register is a single stage. While it holds an untaken
//   result, item.ready stays high only if result.ready is high in that cycle.
// Reset (rst, synchronous): all timestamps, timers, flags and the count clear,
//   the registers return to their defaults (10, 10, 300, 36000).
// Modulus write: the count is brought below the new modulus and its digits are
//   rebuilt, by restoring division and then by conversion to digits. The
//   block holds item.ready low until both are done; writes are still taken.
// ============================================================================
`default_nettype none

module debounced_tenth_second_stopwatch (
  input  wire logic        clk,
  input  wire logic        rst,
  dbsw_item_if.sink        item,
  dbsw_result_if.source    result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic [7:0]  debounce_ticks;
  logic [15:0] tenth_ticks;
  logic [15:0] hold_ticks;
  logic [15:0] count_modulus;

  // stopwatch state
  logic [31:0]        tick_now;
  logic [31:0]        pressed_at  [dbsw_pkg::BUTTON_COUNT];
  logic [31:0]        released_at [dbsw_pkg::BUTTON_COUNT];
  logic [15:0]        count;
  dbsw_pkg::digits_t  digits;
  logic               running;
  logic               paused;
  logic               hold_active;
  logic               ended;
  logic [15:0]        tenth_timer;
  logic               tenth_armed;
  logic [15:0]        hold_timer;

  logic [31:0]        tick_now_next;
  logic [31:0]        pressed_at_next  [dbsw_pkg::BUTTON_COUNT];
  logic [31:0]        released_at_next [dbsw_pkg::BUTTON_COUNT];
  logic [15:0]        count_next;
  dbsw_pkg::digits_t  digits_next;
  logic               running_next;
  logic               paused_next;
  logic               hold_active_next;
  logic               ended_next;
  logic [15:0]        tenth_timer_next;
  logic               tenth_armed_next;
  logic [15:0]        hold_timer_next;

  // result register
  logic        res_valid;
  logic [3:0]  res_shape;
  logic [15:0] res_bcd;
  logic        res_finished;

  logic        emit;
  logic [3:0]  emit_shape;
  logic [15:0] emit_bcd;
  logic        emit_finished;

  // reduction sequencer
  dbsw_pkg::state_t state;
  dbsw_pkg::state_t state_next;
  logic [3:0]       step;
  logic [15:0]      work;
  logic [15:0]      rem;
  logic [16:0]      rem_shift;
  logic [16:0]      rem_sub;
  logic [15:0]      rem_new;
  logic             mod_write;
  logic             step_last;
  logic             item_ready;
  logic             accept;

  // effective limits: zero lengths act as one, modulus clamped to 1..36000
  logic [15:0] tenth_len;
  logic [15:0] hold_len;
  logic [15:0] mod_eff;

  assign tenth_len = (tenth_ticks == 16'd0) ? 16'd1 : tenth_ticks;
  assign hold_len  = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
  assign mod_eff   = (count_modulus == 16'd0) ? 16'd1 :
                     (count_modulus > dbsw_pkg::MODULUS_LIMIT) ? dbsw_pkg::MODULUS_LIMIT :
                     count_modulus;

  assign mod_write = cfg_we && (cfg_index == dbsw_pkg::REG_MODULUS);
  assign step_last = (step == 4'hF);
  assign accept    = item.valid && item_ready;

  // --------------------------------------------------------------------------
  // reduction sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      dbsw_pkg::ST_RUN: begin
        if (mod_write) state_next = dbsw_pkg::ST_DIV;
      end
      dbsw_pkg::ST_DIV: begin
        if (mod_write)      state_next = dbsw_pkg::ST_DIV;
        else if (step_last) state_next = dbsw_pkg::ST_CONV;
      end
      dbsw_pkg::ST_CONV: begin
        if (mod_write)      state_next = dbsw_pkg::ST_DIV;
        else if (step_last) state_next = dbsw_pkg::ST_RUN;
      end
      default: state_next = dbsw_pkg::ST_RUN;
    endcase
  end

  // reduction sequencer: outputs
  always_comb begin
    case (state)
      dbsw_pkg::ST_RUN: item_ready = !res_valid || result.ready;
      default:          item_ready = 1'b0;
    endcase
  end

  assign item.ready = item_ready;

  // restoring division step, remainder only
  assign rem_shift = {1'b0, rem[14:0], work[15]} | {rem[15], 16'd0};
  assign rem_sub   = rem_shift - {1'b0, mod_eff};
  assign rem_new   = (rem_shift >= {1'b0, mod_eff}) ? rem_sub[15:0] : rem_shift[15:0];

  // --------------------------------------------------------------------------
  // single-pass item update
  // --------------------------------------------------------------------------
  logic [31:0] pa;
  logic [31:0] ra;
  logic [31:0] since_release;
  logic        is_press;
  logic        edge_ok;
  logic        hold_expire;
  logic [15:0] count_inc;
  logic        count_wrap;

  assign pa            = pressed_at[item.button];
  assign ra            = released_at[item.button];
  assign since_release = tick_now - ra;
  assign is_press      = (item.level == dbsw_pkg::LEVEL_PRESS);
  assign hold_expire   = hold_active && (hold_timer <= 16'd1);
  assign count_inc     = count + 16'd1;
  // count stays below the modulus, so one compare finds the wrap
  assign count_wrap    = (count_inc >= mod_eff);

  always_comb begin
    tick_now_next    = tick_now;
    pressed_at_next  = pressed_at;
    released_at_next = released_at;
    count_next       = count;
    digits_next      = digits;
    running_next     = running;
    paused_next      = paused;
    hold_active_next = hold_active;
    ended_next       = ended;
    tenth_timer_next = tenth_timer;
    tenth_armed_next = tenth_armed;
    hold_timer_next  = hold_timer;
    emit             = 1'b0;
    emit_shape       = 4'd0;
    emit_bcd         = 16'd0;
    emit_finished    = 1'b0;
    edge_ok          = 1'b0;

    if (item.kind == dbsw_pkg::KIND_TICK) begin
      tick_now_next = tick_now + 32'd1;
      if (!ended) begin
        if (hold_expire) begin
          // finish held long enough: run ends, display blanks
          hold_timer_next  = 16'd0;
          hold_active_next = 1'b0;
          ended_next       = 1'b1;
          running_next     = 1'b0;
          paused_next      = 1'b0;
          count_next       = 16'd0;
          digits_next      = '0;
          tenth_armed_next = 1'b0;
          tenth_timer_next = 16'd0;
          emit             = 1'b1;
          emit_shape       = dbsw_pkg::BLANK_SHAPE;
          emit_finished    = 1'b1;
        end else begin
          if (hold_active) hold_timer_next = hold_timer - 16'd1;
          if (tenth_armed) begin
            if (tenth_timer > 16'd1) begin
              tenth_timer_next = tenth_timer - 16'd1;
            end else begin
              tenth_timer_next = 16'd0;
              tenth_armed_next = 1'b0;
              if (running && !paused) begin
                count_next       = count_wrap ? 16'd0 : count_inc;
                digits_next      = count_wrap ? '0 :
                                   dbsw_pkg::digits_step(digits, 1'b0, 1'b1);
                tenth_timer_next = tenth_len;
                tenth_armed_next = 1'b1;
                emit             = 1'b1;
                emit_shape       = digits_next.tenth;
                emit_bcd         = dbsw_pkg::digits_bcd(digits_next);
              end
            end
          end
        end
      end
    end else if (!ended) begin
      // timestamp debounce
      if (is_press) begin
        edge_ok = !(ra < pa) && (since_release > {24'd0, debounce_ticks});
        if (edge_ok) pressed_at_next[item.button] = tick_now;
      end else begin
        edge_ok = !(pa < ra);
        if (edge_ok) released_at_next[item.button] = tick_now;
      end

      if (edge_ok) begin
        case (item.button)
          dbsw_pkg::BTN_START: begin
            if (is_press && !running) begin
              running_next     = 1'b1;
              tenth_timer_next = tenth_len;
              tenth_armed_next = 1'b1;
              emit             = 1'b1;
              emit_bcd         = dbsw_pkg::digits_bcd(digits);
            end
          end
          dbsw_pkg::BTN_PAUSE: begin
            if (is_press && running) begin
              paused_next      = !paused;
              // pausing drops the tenth timer, resuming starts a fresh period
              tenth_armed_next = paused;
              tenth_timer_next = paused ? tenth_len : 16'd0;
            end
          end
          dbsw_pkg::BTN_RESET: begin
            if (is_press && running) begin
              count_next       = 16'd0;
              digits_next      = '0;
              running_next     = 1'b0;
              paused_next      = 1'b0;
              tenth_armed_next = 1'b0;
              tenth_timer_next = 16'd0;
              emit             = 1'b1;
            end
          end
          dbsw_pkg::BTN_FINISH: begin
            hold_active_next = is_press;
            hold_timer_next  = is_press ? hold_len : 16'd0;
          end
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= dbsw_pkg::DEBOUNCE_RESET;
      tenth_ticks    <= dbsw_pkg::TENTH_RESET;
      hold_ticks     <= dbsw_pkg::HOLD_RESET;
      count_modulus  <= dbsw_pkg::MODULUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dbsw_pkg::REG_DEBOUNCE: debounce_ticks <= cfg_data[7:0];
        dbsw_pkg::REG_TENTH:    tenth_ticks    <= cfg_data;
        dbsw_pkg::REG_HOLD:     hold_ticks     <= cfg_data;
        dbsw_pkg::REG_MODULUS:  count_modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbsw_pkg::ST_RUN;
      step  <= 4'd0;
      work  <= 16'd0;
      rem   <= 16'd0;
    end else begin
      state <= state_next;
      if (mod_write) begin
        step <= 4'd0;
        work <= count;
        rem  <= 16'd0;
      end else begin
        case (state)
          dbsw_pkg::ST_DIV: begin
            step <= step + 4'd1;
            if (step_last) begin
              work <= rem_new;
              rem  <= 16'd0;
            end else begin
              work <= {work[14:0], 1'b0};
              rem  <= rem_new;
            end
          end
          dbsw_pkg::ST_CONV: begin
            step <= step + 4'd1;
            work <= {work[14:0], 1'b0};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now    <= 32'd0;
      pressed_at  <= '{default: 32'd0};
      released_at <= '{default: 32'd0};
      count       <= 16'd0;
      digits      <= '0;
      running     <= 1'b0;
      paused      <= 1'b0;
      hold_active <= 1'b0;
      ended       <= 1'b0;
      tenth_timer <= 16'd0;
      tenth_armed <= 1'b0;
      hold_timer  <= 16'd0;
    end else if (accept) begin
      tick_now    <= tick_now_next;
      pressed_at  <= pressed_at_next;
      released_at <= released_at_next;
      count       <= count_next;
      digits      <= digits_next;
      running     <= running_next;
      paused      <= paused_next;
      hold_active <= hold_active_next;
      ended       <= ended_next;
      tenth_timer <= tenth_timer_next;
      tenth_armed <= tenth_armed_next;
      hold_timer  <= hold_timer_next;
    end else if (!mod_write) begin
      // reduced count lands at the end of division; digits rebuilt MSB first
      case (state)
        dbsw_pkg::ST_DIV: begin
          if (step_last) begin
            count  <= rem_new;
            digits <= '0;
          end
        end
        dbsw_pkg::ST_CONV: digits <= dbsw_pkg::digits_step(digits, 1'b1, work[15]);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_shape    <= emit_shape;
      res_bcd      <= emit_bcd;
      res_finished <= emit_finished;
    end
  end

  assign result.valid       = res_valid;
  assign result.glyph       = res_shape;
  assign result.display_bcd = res_bcd;
  assign result.finished    = res_finished;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_below_modulus: assert property (@(posedge clk) disable iff (rst)
    (state == dbsw_pkg::ST_RUN) |-> (count < mod_eff))
    else $error("count not below modulus while taking items");

  a_armed_nonzero: assert property (@(posedge clk) disable iff (rst)
    tenth_armed |-> (tenth_timer != 16'd0))
    else $error("tenth timer armed at zero");

  a_end_reports: assert property (@(posedge clk) disable iff (rst)
    $rose(ended) |-> (res_valid && res_finished))
    else $error("run ended without a finished result");

  a_ended_quiet: assert property (@(posedge clk) disable iff (rst)
    ended |-> (!running && !tenth_armed && !hold_active))
    else $error("activity after the run ended");

  a_tenth_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == dbsw_pkg::ST_RUN && count == 16'd0) |-> (digits == '0))
    else $error("digits out of step with count");

endmodule

`default_nettype wire
